// ----- hw/rtl/tcprc_pkg.sv -----
// Shared types, codes and constants for the three-channel predictive residual check.
package tcprc_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned PHASE_W = 2;
    localparam int unsigned INDEX_W = 3;
    localparam int unsigned CHAN_N  = 3;

    // Configuration register indexes.
    localparam logic [INDEX_W-1:0] CFG_HIST_A = 3'd0;
    localparam logic [INDEX_W-1:0] CFG_HIST_B = 3'd1;
    localparam logic [INDEX_W-1:0] CFG_HIST_C = 3'd2;
    localparam logic [INDEX_W-1:0] CFG_PRED   = 3'd3;
    localparam logic [INDEX_W-1:0] CFG_PHASE  = 3'd4;

    // Channel positions in rotation.
    localparam logic [1:0] CH_ONE   = 2'd0;
    localparam logic [1:0] CH_TWO   = 2'd1;
    localparam logic [1:0] CH_THREE = 2'd2;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK            = 2'd0,
        STATUS_BASE_MISMATCH = 2'd1,
        STATUS_FIXED_CHANGED = 2'd2,
        STATUS_NO_RECON      = 2'd3
    } status_t;

    // History, predictor and phase; also the shape of the start values.
    typedef struct packed {
        logic [DATA_W-1:0]  hist_a;
        logic [DATA_W-1:0]  hist_b;
        logic [DATA_W-1:0]  hist_c;
        logic [DATA_W-1:0]  pred;
        logic [PHASE_W-1:0] phase;
    } hist_state_t;

    // One sample frame as held in the input register.
    typedef struct packed {
        logic [DATA_W-1:0]               carrier;
        logic [CHAN_N-1:0][DATA_W-1:0]   chan;
        logic [CHAN_N-1:0][DATA_W-1:0]   base;
        logic                            run_start;
    } frame_t;

endpackage

// ----- hw/rtl/three_channel_predictive_residual_check_top.sv -----
// Top level of the three-channel predictive residual check.
//
// Input channel: in_valid / in_stall carry one sample frame per beat (carrier,
// three samples, three baselines, run_start). Output channel: out_valid /
// out_stall carry one result beat per frame (two residuals and a status).
// A beat moves at a rising edge with valid high and stall low.
// The frame is captured in an input register; once the result register is free,
// the frame is evaluated against the history state and the result register is
// loaded, from which the result beat is presented until it is taken.
// One frame per cycle is sustained while the receiver does not stall; the history
// update closes in that evaluation cycle, which sets the figure.
// Configuration writes (cfg_write, cfg_index, cfg_data) set the run start
// values; write them only while the block is idle.
// Reset clears the history, the start values and both valid flags.
// While the receiver stalls a full result register, the input register holds
// its frame and in_stall rises once it is occupied; nothing is dropped.
module three_channel_predictive_residual_check_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [tcprc_pkg::DATA_W-1:0]    carrier_sample,
    input  logic signed [tcprc_pkg::DATA_W-1:0]    chan_one,
    input  logic signed [tcprc_pkg::DATA_W-1:0]    chan_two,
    input  logic signed [tcprc_pkg::DATA_W-1:0]    chan_three,
    input  logic signed [tcprc_pkg::DATA_W-1:0]    base_one,
    input  logic signed [tcprc_pkg::DATA_W-1:0]    base_two,
    input  logic signed [tcprc_pkg::DATA_W-1:0]    base_three,
    input  logic                                   run_start,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [tcprc_pkg::DATA_W-1:0]    residual_first,
    output logic signed [tcprc_pkg::DATA_W-1:0]    residual_second,
    output logic [1:0]                             status,
    input  logic                                   cfg_write,
    input  logic [tcprc_pkg::INDEX_W-1:0]          cfg_index,
    input  logic [tcprc_pkg::DATA_W-1:0]           cfg_data
);
    import tcprc_pkg::*;

    hist_state_t       start_state;
    hist_state_t       state_reg;
    hist_state_t       state_next;
    frame_t            frame_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] res_first_reg;
    logic [DATA_W-1:0] res_second_reg;
    status_t           status_reg;
    logic [DATA_W-1:0] res_first;
    logic [DATA_W-1:0] res_second;
    status_t           status_code;
    logic              advance;
    logic              in_take;

    tcprc_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start_state (start_state)
    );

    tcprc_eval u_eval (
        .frame       (frame_reg),
        .cur_state   (state_reg),
        .start_state (start_state),
        .res_first   (res_first),
        .res_second  (res_second),
        .status_code (status_code),
        .state_next  (state_next)
    );

    // The result register frees up when empty or when its beat is taken.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // Input valid flag, history state and output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance && in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Frame capture.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            frame_reg.carrier   <= carrier_sample;
            frame_reg.chan[0]   <= chan_one;
            frame_reg.chan[1]   <= chan_two;
            frame_reg.chan[2]   <= chan_three;
            frame_reg.base[0]   <= base_one;
            frame_reg.base[1]   <= base_two;
            frame_reg.base[2]   <= base_three;
            frame_reg.run_start <= run_start;
        end
    end

    // Result capture.
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            res_first_reg  <= res_first;
            res_second_reg <= res_second;
            status_reg     <= status_code;
        end
    end

    assign out_valid       = out_valid_reg;
    assign residual_first  = res_first_reg;
    assign residual_second = res_second_reg;
    assign status          = status_reg;

endmodule

// ----- hw/rtl/tcprc_cfg.sv -----
// Configuration register file holding the run start values.
module tcprc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [tcprc_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [tcprc_pkg::DATA_W-1:0]   cfg_data,
    output tcprc_pkg::hist_state_t         start_state
);
    import tcprc_pkg::*;

    hist_state_t start_reg;
    hist_state_t start_next;

    // Decode the write; indexes beyond the list are ignored.
    always_comb
    begin
        start_next = start_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_HIST_A: start_next.hist_a = cfg_data;
                CFG_HIST_B: start_next.hist_b = cfg_data;
                CFG_HIST_C: start_next.hist_c = cfg_data;
                CFG_PRED:   start_next.pred   = cfg_data;
                CFG_PHASE:  start_next.phase  = cfg_data[PHASE_W-1:0];
                default:    start_next        = start_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
        end
        else
        begin
            start_reg <= start_next;
        end
    end

    assign start_state = start_reg;

endmodule

// ----- hw/rtl/tcprc_eval.sv -----
// Single-pass evaluation of one frame against the history: checks, residuals, next state.
module tcprc_eval (
    input  tcprc_pkg::frame_t              frame,
    input  tcprc_pkg::hist_state_t         cur_state,
    input  tcprc_pkg::hist_state_t         start_state,
    output logic [tcprc_pkg::DATA_W-1:0]   res_first,
    output logic [tcprc_pkg::DATA_W-1:0]   res_second,
    output tcprc_pkg::status_t             status_code,
    output tcprc_pkg::hist_state_t         state_next
);
    import tcprc_pkg::*;

    hist_state_t       eff;
    logic [1:0]        fx;
    logic [1:0]        ex;
    logic [1:0]        fr;
    logic [1:0]        lo;
    logic [1:0]        hi;
    logic [1:0]        phase_n;
    logic [DATA_W-1:0] next_pred;
    logic [DATA_W-1:0] scaled;
    logic [DATA_W-1:0] est;
    logic [DATA_W-1:0] diff_lo;
    logic [DATA_W-1:0] diff_hi;
    logic [DATA_W-1:0] recon;

    // A run start replaces the history with the configured values first.
    assign eff = frame.run_start ? start_state : cur_state;

    // Rotation: fixed, estimated and remaining channel, plus the residual pair.
    // A phase of three behaves as phase zero.
    always_comb
    begin
        case (eff.phase)
            2'd1:
            begin
                fx = CH_TWO;   ex = CH_THREE; fr = CH_ONE;
                lo = CH_ONE;   hi = CH_THREE; phase_n = 2'd2;
            end
            2'd2:
            begin
                fx = CH_THREE; ex = CH_ONE;   fr = CH_TWO;
                lo = CH_ONE;   hi = CH_TWO;   phase_n = 2'd0;
            end
            default:
            begin
                fx = CH_ONE;   ex = CH_TWO;   fr = CH_THREE;
                lo = CH_TWO;   hi = CH_THREE; phase_n = 2'd1;
            end
        endcase
    end

    // Predictor 4a - 3b. The estimate (3*next + b)/4 equals (12a - 8b)/4, which is
    // always a multiple of four, so truncation reduces to dropping two bits and
    // filling the top three bits from the sign of the scaled sum.
    assign next_pred = (eff.hist_a << 2) - (eff.hist_b + (eff.hist_b << 1));
    assign scaled    = (eff.hist_a << 3) + (eff.hist_a << 2) - (eff.hist_b << 3);
    assign est       = {{3{scaled[DATA_W-1]}}, scaled[DATA_W-2:2]};

    // Residuals of the two non-fixed channels and the reconstruction sum.
    assign diff_lo = frame.chan[lo] - frame.base[lo];
    assign diff_hi = frame.chan[hi] - frame.base[hi];
    assign recon   = frame.base[0] + frame.base[1] + frame.base[2] + diff_lo + diff_hi;

    // Checks in priority order: baselines, fixed channel, reconstruction.
    always_comb
    begin
        if ((frame.base[fx] != eff.pred) || (frame.base[ex] != est))
        begin
            status_code = STATUS_BASE_MISMATCH;
        end
        else if (frame.chan[fx] != frame.base[fx])
        begin
            status_code = STATUS_FIXED_CHANGED;
        end
        else if (recon != frame.carrier)
        begin
            status_code = STATUS_NO_RECON;
        end
        else
        begin
            status_code = STATUS_OK;
        end
    end

    // Outputs and state advance only on success; a failed frame keeps the (run-start adjusted) state.
    always_comb
    begin
        if (status_code == STATUS_OK)
        begin
            res_first         = diff_lo;
            res_second        = diff_hi;
            state_next.hist_a = frame.base[fr];
            state_next.hist_b = eff.hist_c;
            state_next.hist_c = eff.pred;
            state_next.pred   = next_pred;
            state_next.phase  = phase_n;
        end
        else
        begin
            res_first  = '0;
            res_second = '0;
            state_next = eff;
        end
    end

endmodule

// ----- hw/rtl/tcprc_checker.sv -----
// Port-level assertions for the residual check top level, with their bind.
module tcprc_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_stall,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic signed [tcprc_pkg::DATA_W-1:0]    residual_first,
    input logic signed [tcprc_pkg::DATA_W-1:0]    residual_second,
    input logic [1:0]                             status
);
    import tcprc_pkg::*;

    // Back pressure on the input only comes from a stalled, full result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled result beat");

    // A failed frame reports zero residuals.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STATUS_OK)) |->
            ((residual_first == '0) && (residual_second == '0)))
        else $error("error result carries nonzero residuals");

    // A stalled result beat stays and holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(residual_first) && $stable(residual_second)
             && $stable(status)))
        else $error("stalled result beat changed or vanished");

endmodule

bind three_channel_predictive_residual_check_top tcprc_checker u_tcprc_checker (.*);

// ----- sim/tb_top.sv -----
// Self-checking testbench for the three-channel predictive residual check.
`timescale 1ns / 1ps

module tb_top;
    import tcprc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int N_PLAN       = 22;
    localparam int N_SETTINGS   = 6;
    localparam int ITEMS_PER_SET = 72;
    localparam int DRAIN_CYCLES = 8;

    // How a frame is made to fit the predicted state before it is sent.
    typedef enum logic [2:0] {
        SHAPE_RAW,
        SHAPE_CLEAN,
        SHAPE_BAD_BASE,
        SHAPE_BAD_FIXED,
        SHAPE_BAD_SUM
    } shape_t;

    typedef struct packed {
        logic             start;
        logic [31:0]      carrier;
        logic [2:0][31:0] chan;
        logic [2:0][31:0] base;
    } stim_frame_t;

    typedef struct packed {
        logic [31:0] first;
        logic [31:0] second;
        status_t     st;
    } outcome_t;

    typedef struct packed {
        shape_t      shape;
        logic        start;
        logic [31:0] carrier;
        logic [31:0] c1;
        logic [31:0] c2;
        logic [31:0] c3;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] b3;
        logic        typed;
        logic [31:0] want_first;
        logic [31:0] want_second;
        status_t     want_status;
    } plan_row_t;

    // Directed frames; the expected result is written out where it is obvious.
    plan_row_t plan_rows [N_PLAN] = '{
        '{SHAPE_RAW, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
          32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0, 32'h0, STATUS_OK},
        '{SHAPE_RAW, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h0, 32'h0,
          STATUS_BASE_MISMATCH},
        '{SHAPE_RAW, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0, 32'h0,
          STATUS_BASE_MISMATCH},
        '{SHAPE_RAW, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, 32'h0,
          STATUS_BASE_MISMATCH},
        '{SHAPE_RAW, 1'b1, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
          32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0, 32'h0,
          STATUS_NO_RECON},
        '{SHAPE_RAW, 1'b0, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000,
          32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0, 32'h0,
          STATUS_FIXED_CHANGED},
        '{SHAPE_RAW, 1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
          32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0, 32'h0, STATUS_OK},
        '{SHAPE_CLEAN, 1'b0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 32'h0, STATUS_OK},
        '{SHAPE_CLEAN, 1'b0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, STATUS_OK},
        '{SHAPE_CLEAN, 1'b0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, STATUS_OK},
        '{SHAPE_BAD_BASE, 1'b0, 32'h0, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
          32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 1'b1, 32'h0, 32'h0,
          STATUS_BASE_MISMATCH},
        '{SHAPE_BAD_FIXED, 1'b0, 32'h0, 32'h0000_0001, 32'hFFFF_FFFE, 32'h0000_0001,
          32'hFFFF_FFFE, 32'h0000_0001, 32'hFFFF_FFFE, 1'b1, 32'h0, 32'h0,
          STATUS_FIXED_CHANGED},
        '{SHAPE_BAD_SUM, 1'b0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0, 32'h0,
          STATUS_NO_RECON},
        '{SHAPE_CLEAN, 1'b0, 32'h0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hA5A5_A5A5,
          32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, 32'h0, 32'h0, STATUS_OK},
        '{SHAPE_CLEAN, 1'b0, 32'h0, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
          32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b0, 32'h0, 32'h0, STATUS_OK},
        '{SHAPE_BAD_BASE, 1'b0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0, 32'h0,
          STATUS_BASE_MISMATCH},
        '{SHAPE_BAD_FIXED, 1'b0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h0, 32'h0,
          STATUS_FIXED_CHANGED},
        '{SHAPE_BAD_SUM, 1'b0, 32'h0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
          32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0, 32'h0,
          STATUS_NO_RECON},
        '{SHAPE_CLEAN, 1'b1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, STATUS_OK},
        '{SHAPE_CLEAN, 1'b0, 32'h0, 32'h0000_0001, 32'hFFFF_FFFE, 32'h8000_0001,
          32'h7FFF_FFFE, 32'h0000_0001, 32'hFFFF_FFFE, 1'b0, 32'h0, 32'h0, STATUS_OK},
        '{SHAPE_BAD_SUM, 1'b1, 32'h0, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0F0F_0F0F,
          32'hF0F0_F0F0, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b1, 32'h0, 32'h0,
          STATUS_NO_RECON},
        '{SHAPE_CLEAN, 1'b0, 32'h0, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9,
          32'h8765_4321, 32'hDEAD_0001, 32'h7777_8888, 1'b0, 32'h0, 32'h0, STATUS_OK}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] carrier_sample = '0;
    logic [31:0] chan_one = '0;
    logic [31:0] chan_two = '0;
    logic [31:0] chan_three = '0;
    logic [31:0] base_one = '0;
    logic [31:0] base_two = '0;
    logic [31:0] base_three = '0;
    logic        run_start = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] residual_first;
    logic [31:0] residual_second;
    logic [1:0]  status;
    logic        cfg_write = 1'b0;
    logic [INDEX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // Predicted history state and the run start values behind it.
    logic [31:0] newest, second, third, guess;
    logic [1:0]  turn;
    logic [31:0] start_newest, start_second, start_third, start_guess;
    logic [1:0]  start_turn;

    outcome_t    outcomes_due [$];
    int          n_fail = 0;
    int          cycle_count = 0;
    bit          quiet_mode = 1'b0;

    three_channel_predictive_residual_check_top dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, outcomes_due.size());
            $display("FAIL");
            $finish;
        end
    end

    // Linear predictor and its quarter estimate, truncated toward zero.
    function automatic void forecast(input logic [31:0] a, input logic [31:0] b,
                                     output logic [31:0] nxt, output logic [31:0] est);
        logic signed [31:0] mix;
        nxt = 32'd4 * a - 32'd3 * b;
        mix = 32'd3 * nxt + b;
        est = mix / 32'sd4;
    endfunction

    // Fixed, estimated and free channel for a phase, plus the two residual channels.
    function automatic void rotation(input logic [1:0] phase, output logic [1:0] fx,
                                     output logic [1:0] ex, output logic [1:0] fr,
                                     output logic [1:0] lo, output logic [1:0] hi);
        fx = (phase == 2'd3) ? CH_ONE : phase;
        case (fx)
            CH_ONE:   begin ex = CH_TWO;   fr = CH_THREE; end
            CH_TWO:   begin ex = CH_THREE; fr = CH_ONE;   end
            default:  begin ex = CH_ONE;   fr = CH_TWO;   end
        endcase
        lo = (fx == CH_ONE) ? CH_TWO : CH_ONE;
        hi = (fx == CH_THREE) ? CH_TWO : CH_THREE;
    endfunction

    // Work out the result of one accepted frame and advance the history.
    function automatic outcome_t predict_outcome(input stim_frame_t f);
        logic [31:0] nxt, est, total;
        logic [1:0]  fx, ex, fr, lo, hi;
        outcome_t    o;
        if (f.start)
        begin
            newest = start_newest;
            second = start_second;
            third  = start_third;
            guess  = start_guess;
            turn   = start_turn;
        end
        forecast(newest, second, nxt, est);
        rotation(turn, fx, ex, fr, lo, hi);
        o = '{first: 32'h0, second: 32'h0, st: STATUS_OK};
        if (f.base[fx] != guess || f.base[ex] != est)
            o.st = STATUS_BASE_MISMATCH;
        else if (f.chan[fx] != f.base[fx])
            o.st = STATUS_FIXED_CHANGED;
        else
        begin
            o.first  = f.chan[lo] - f.base[lo];
            o.second = f.chan[hi] - f.base[hi];
            total = f.base[CH_ONE] + f.base[CH_TWO] + f.base[CH_THREE] + o.first + o.second;
            if (total != f.carrier)
                o.st = STATUS_NO_RECON;
        end
        if (o.st != STATUS_OK)
        begin
            o.first  = 32'h0;
            o.second = 32'h0;
        end
        else
        begin
            newest = f.base[fr];
            second = third;
            third  = guess;
            guess  = nxt;
            turn   = (fx == CH_THREE) ? CH_ONE : fx + 2'd1;
        end
        return o;
    endfunction

    // Overwrite the checked fields so the frame passes, then break one check if asked.
    function automatic stim_frame_t fit_frame(input stim_frame_t f, input shape_t k);
        logic [31:0] ha, hb, hp, nxt, est, flip;
        logic [1:0]  ph, fx, ex, fr, lo, hi;
        if (k == SHAPE_RAW)
            return f;
        ha = f.start ? start_newest : newest;
        hb = f.start ? start_second : second;
        hp = f.start ? start_guess : guess;
        ph = f.start ? start_turn : turn;
        forecast(ha, hb, nxt, est);
        rotation(ph, fx, ex, fr, lo, hi);
        f.base[fx] = hp;
        f.base[ex] = est;
        f.chan[fx] = hp;
        f.carrier  = hp + f.chan[lo] + f.chan[hi];
        flip = $urandom;
        if (flip == 32'h0)
            flip = 32'h1;
        case (k)
            SHAPE_BAD_BASE:
                if ($urandom_range(1, 0) == 1)
                    f.base[fx] ^= flip;
                else
                    f.base[ex] ^= flip;
            SHAPE_BAD_FIXED: f.chan[fx] ^= flip;
            SHAPE_BAD_SUM:   f.carrier ^= flip;
            default: ;
        endcase
        return f;
    endfunction

    // Mostly random words, with the extremes and small values mixed in.
    function automatic logic [31:0] any_word();
        case ($urandom_range(15, 0))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return $urandom_range(3, 0) - 2;
            default: return $urandom;
        endcase
    endfunction

    // Idle length: mostly none, sometimes short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(99, 0);
        if (quiet_mode || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        n_fail++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endtask

    // Send one beat and record its expected result once it is taken.
    task automatic push_frame(input stim_frame_t f, input logic typed, input outcome_t want);
        int       gap;
        outcome_t predicted;
        gap = gap_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        carrier_sample <= f.carrier;
        chan_one       <= f.chan[CH_ONE];
        chan_two       <= f.chan[CH_TWO];
        chan_three     <= f.chan[CH_THREE];
        base_one       <= f.base[CH_ONE];
        base_two       <= f.base[CH_TWO];
        base_three     <= f.base[CH_THREE];
        run_start      <= f.start;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        predicted = predict_outcome(f);
        outcomes_due.insert(outcomes_due.size(), typed ? want : predicted);
    endtask

    // Drain the block, then write all five start registers.
    task automatic load_settings(input logic [31:0] ha, input logic [31:0] hb,
                                 input logic [31:0] hc, input logic [31:0] hp,
                                 input logic [31:0] ph);
        logic [INDEX_W-1:0] idx [5];
        logic [31:0]        val [5];
        idx = '{CFG_HIST_A, CFG_HIST_B, CFG_HIST_C, CFG_PRED, CFG_PHASE};
        val = '{ha, hb, hc, hp, ph};
        in_valid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        for (int i = 0; i < 5; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        start_newest = ha;
        start_second = hb;
        start_third  = hc;
        start_guess  = hp;
        start_turn   = ph[1:0];
    endtask

    // Result side: random stall pattern and in-order checking.
    initial
    begin : result_side
        int       stall_left;
        int       run_left;
        outcome_t want;
        stall_left = 0;
        run_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (outcomes_due.size() == 0)
                begin
                    n_fail++;
                    $display("%0t: unexpected result, expected none, actual %h %h status %0d",
                             $time, residual_first, residual_second, status);
                end
                else
                begin
                    want = outcomes_due.pop_front();
                    if (residual_first !== want.first)
                        flag_mismatch("residual_first", want.first, residual_first);
                    if (residual_second !== want.second)
                        flag_mismatch("residual_second", want.second, residual_second);
                    if (status !== want.st)
                        flag_mismatch("status", {30'h0, want.st}, {30'h0, status});
                end
            end
            if (stall_left != 0)
                stall_left--;
            else if (run_left != 0)
                run_left--;
            else
            begin
                run_left = $urandom_range(20, 1);
                stall_left = gap_len();
            end
            out_stall <= (stall_left != 0);
        end
    end

    // Stimulus: reset, directed frames, then random frames under several settings.
    initial
    begin : stimulus
        stim_frame_t f;
        outcome_t    want;
        shape_t      k;
        int          r;
        logic [31:0] word;
        newest = '0; second = '0; third = '0; guess = '0; turn = '0;
        start_newest = '0; start_second = '0; start_third = '0; start_guess = '0;
        start_turn = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_rows[i])
        begin
            f.start   = plan_rows[i].start;
            f.carrier = plan_rows[i].carrier;
            f.chan    = {plan_rows[i].c3, plan_rows[i].c2, plan_rows[i].c1};
            f.base    = {plan_rows[i].b3, plan_rows[i].b2, plan_rows[i].b1};
            want = '{first: plan_rows[i].want_first, second: plan_rows[i].want_second,
                     st: plan_rows[i].want_status};
            push_frame(fit_frame(f, plan_rows[i].shape), plan_rows[i].typed, want);
        end

        for (int s = 0; s < N_SETTINGS; s++)
        begin
            word = $urandom & 32'hFFFF_FFFC;
            case (s)
                0: load_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 32'h8000_0000, word | 32'd2);
                1: load_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 32'h7FFF_FFFF, word | 32'd1);
                2: load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF, word | 32'd3);
                3: load_settings(32'h0, 32'h0, 32'h0, 32'h0, word);
                default: load_settings(any_word(), any_word(), any_word(), any_word(),
                                       word | $urandom_range(3, 0));
            endcase
            // One setting runs with no idling on either side.
            quiet_mode = (s == 3);
            for (int i = 0; i < ITEMS_PER_SET; i++)
            begin
                f.start   = (i == 0) || ($urandom_range(24, 0) == 0);
                f.carrier = any_word();
                f.chan    = {any_word(), any_word(), any_word()};
                f.base    = {any_word(), any_word(), any_word()};
                r = $urandom_range(99, 0);
                if (r < 70)
                    k = SHAPE_CLEAN;
                else if (r < 78)
                    k = SHAPE_BAD_BASE;
                else if (r < 86)
                    k = SHAPE_BAD_FIXED;
                else if (r < 94)
                    k = SHAPE_BAD_SUM;
                else
                    k = SHAPE_RAW;
                push_frame(fit_frame(f, k), 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_fail == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
